// ===== hdl/greatest_prime_factor_sieve_top_assert.svh =====
// Assertion helpers for the sieve block; clk_i and rst_ni must be in scope.
`ifndef GREATEST_PRIME_FACTOR_SIEVE_TOP_ASSERT_SVH
`define GREATEST_PRIME_FACTOR_SIEVE_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define GPFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define GPFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gpfs_pkg.sv =====
`default_nettype none

package gpfs_pkg;

  localparam int unsigned LIM_W = 16;
  localparam int unsigned LIM_MAX = (2 ** LIM_W) - 1;
  localparam int unsigned TABLE_DEPTH_DEF = 65536;
  localparam int unsigned FIRST_PRIME = 2;

  typedef logic [LIM_W-1:0] lim_t;
  typedef logic [LIM_W:0]   lim_ext_t;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

endpackage

`default_nettype wire

// ===== hdl/gpfs_ram.sv =====
`default_nettype none

module gpfs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/greatest_prime_factor_sieve_top.sv =====
// Greatest prime factor table.
// A transaction is taken when start_i is high and busy_o is low. Commands:
// read an entry, build the table up to request_limit_i, clear, or no-op.
// Every transaction gives one result, shown for one cycle with done_o high;
// the receiver cannot hold it off.
// Read, clear and no-op: result in the cycle after acceptance, busy_o stays
// low, so one such transaction per cycle. Reads go through the table RAM's
// registered read port.
// Build (limit above the current one): busy_o rises for the whole build.
// The build fills entry i with i for every i up to limit, then walks p = 2,3,...
// while 2p <= limit: a read state and a test state per p, and for each p
// found prime, one write per multiple 2p..limit that overwrites it with p.
// Primes go in rising order, so each entry ends with its largest prime.
// All writes go through the single write port of the table RAM.
// Reset clears the built limit; the table RAM is not cleared and entries are
// only served up to and including the built limit.
`default_nettype none
`include "greatest_prime_factor_sieve_top_assert.svh"

module greatest_prime_factor_sieve_top #(
  parameter int unsigned TABLE_DEPTH = gpfs_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] request_limit_i,
  input  wire logic [15:0] query_index_i,
  output      logic        done_o,
  output      logic [15:0] factor_o,
  output      logic        index_in_range_o,
  output      logic [15:0] built_limit_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned MaxLim = (TABLE_DEPTH - 1 > gpfs_pkg::LIM_MAX) ?
                                   gpfs_pkg::LIM_MAX : TABLE_DEPTH - 1;
  localparam gpfs_pkg::lim_t MaxLimV = gpfs_pkg::lim_t'(MaxLim);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_PRIME_RD,
    ST_PRIME_TEST,
    ST_SWEEP
  } state_e;

  state_e             state_q;
  gpfs_pkg::lim_t     covered_q;
  gpfs_pkg::lim_t     lim_q;
  gpfs_pkg::lim_t     ptr_q;
  gpfs_pkg::lim_t     p_q;
  logic               done_q;
  logic               in_range_q;
  logic               use_ram_q;

  gpfs_pkg::cmd_e     cmd;
  gpfs_pkg::lim_t     req_sat;
  gpfs_pkg::lim_ext_t twice_p;
  gpfs_pkg::lim_ext_t next_mult;
  logic               accept;
  logic               query_ok;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  gpfs_pkg::lim_t     ram_wdata;
  logic [AddrW-1:0]   ram_raddr;
  gpfs_pkg::lim_t     ram_rdata;

  assign cmd       = gpfs_pkg::cmd_e'(command_i);
  assign req_sat   = (request_limit_i > MaxLimV) ? MaxLimV : request_limit_i;
  assign accept    = start_i && (state_q == ST_IDLE);
  assign query_ok  = (query_index_i <= covered_q);
  assign twice_p   = {p_q, 1'b0};
  assign next_mult = {1'b0, ptr_q} + {1'b0, p_q};

  // Table RAM port control; no read whose data is used meets a write to the
  // same entry in the same cycle, so no forwarding path is needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AddrW'(ptr_q);
    ram_wdata = ptr_q;
    ram_raddr = AddrW'(query_index_i);
    unique case (state_q)
      ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_PRIME_RD: begin
        ram_raddr = AddrW'(p_q);
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_wdata = p_q;
      end
      default: begin
      end
    endcase
  end

  gpfs_ram #(
    .WIDTH (gpfs_pkg::LIM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      covered_q  <= '0;
      lim_q      <= '0;
      ptr_q      <= '0;
      p_q        <= '0;
      done_q     <= 1'b0;
      in_range_q <= 1'b0;
      use_ram_q  <= 1'b0;
    end else begin
      done_q     <= 1'b0;
      in_range_q <= 1'b0;
      use_ram_q  <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              gpfs_pkg::CMD_READ: begin
                done_q     <= 1'b1;
                in_range_q <= query_ok;
                // index zero answers 0 without touching the table
                use_ram_q  <= query_ok && (query_index_i != '0);
              end
              gpfs_pkg::CMD_BUILD: begin
                if (req_sat > covered_q) begin
                  lim_q   <= req_sat;
                  ptr_q   <= '0;
                  state_q <= ST_FILL;
                end else begin
                  done_q <= 1'b1;
                end
              end
              gpfs_pkg::CMD_CLEAR: begin
                covered_q <= '0;
                done_q    <= 1'b1;
              end
              gpfs_pkg::CMD_NOP: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        ST_FILL: begin
          if (ptr_q == lim_q) begin
            p_q     <= gpfs_pkg::lim_t'(gpfs_pkg::FIRST_PRIME);
            state_q <= ST_PRIME_RD;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        ST_PRIME_RD: begin
          // no multiple left to mark: the table is complete
          if (twice_p > {1'b0, lim_q}) begin
            covered_q <= lim_q;
            done_q    <= 1'b1;
            state_q   <= ST_IDLE;
          end else begin
            state_q <= ST_PRIME_TEST;
          end
        end
        ST_PRIME_TEST: begin
          // an entry still holding its own index has no smaller prime factor
          if (ram_rdata == p_q) begin
            ptr_q   <= gpfs_pkg::lim_t'(twice_p);
            state_q <= ST_SWEEP;
          end else begin
            p_q     <= p_q + 1'b1;
            state_q <= ST_PRIME_RD;
          end
        end
        ST_SWEEP: begin
          if (next_mult > {1'b0, lim_q}) begin
            p_q     <= p_q + 1'b1;
            state_q <= ST_PRIME_RD;
          end else begin
            ptr_q <= gpfs_pkg::lim_t'(next_mult);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign index_in_range_o = in_range_q;
  assign factor_o         = use_ram_q ? ram_rdata : '0;
  assign built_limit_o    = covered_q;

  `GPFS_ASSERT_NEXT(a_read_next_cycle, start_i && !busy_o && command_i == gpfs_pkg::CMD_READ, done_o, "read result not delivered in the next cycle")
  `GPFS_ASSERT(a_quiet_outputs, !done_o |-> (factor_o == '0 && !index_in_range_o), "result fields active without strobe")
  `GPFS_ASSERT(a_limit_saturated, covered_q <= MaxLimV, "built limit beyond table depth")
  `GPFS_ASSERT(a_sweep_bounds, (state_q == ST_SWEEP) |-> (ptr_q > p_q && ptr_q <= lim_q), "sweep write outside the multiples of p")

endmodule

`default_nettype wire
